[sv/single_occurrence_counter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Single occurrence counter assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SINGLE_OCCURRENCE_COUNTER_UNIT_MACROS_SVH
`define SINGLE_OCCURRENCE_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SOCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("socu assertion failed");

// next-cycle implication, disabled in reset
`define SOCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("socu assertion failed");

`endif

[sv/socu_pkg.sv]
// ----------------------------------------------------------------------------
// Single occurrence counter package
// Shared widths, defaults, mark codes and result type.
// ----------------------------------------------------------------------------
package socu_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 11;
	localparam int OUT_DATA_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

	// mark bit stored beside each value
	localparam logic MARK_ONCE  = 1'b0;
	localparam logic MARK_MULTI = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] once_count;
		logic               overflow;
	} res_t;

endpackage

[sv/socu_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module socu_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/socu_seq.sv]
// ----------------------------------------------------------------------------
// Single occurrence counter sequencer
// Scans the used entries through one read port and one comparator, then
// updates or appends at most one entry and keeps the running counts.
// ----------------------------------------------------------------------------
module socu_seq
	import socu_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [VALUE_BITS-1:0]       key,
	input  logic                        last,
	output logic                        wr_en,
	output logic [$clog2(CAPACITY)-1:0] wr_addr,
	output logic [VALUE_BITS:0]         wr_data,
	output logic                        rd_en,
	output logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [VALUE_BITS:0]         rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output res_t                        res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int UW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [VALUE_BITS-1:0] key_q;
	logic                last_q;
	logic [UW-1:0]       idx_q;
	logic                cmp_v_q;
	logic [UW-1:0]       cmp_idx_q;
	logic [UW-1:0]       used_q;
	logic [UW-1:0]       once_q;
	logic                ovf_q;

	logic issue;
	logic hit;
	logic miss;
	logic full;
	logic sat;

	assign issue = (state_q == ST_SCAN) && (idx_q < used_q);
	assign hit   = (state_q == ST_SCAN) && cmp_v_q && (rd_data[VALUE_BITS-1:0] == key_q);
	assign miss  = (state_q == ST_SCAN) && !issue && !cmp_v_q;
	assign full  = (used_q == UW'(CAPACITY));

	assign in_ready = (state_q == ST_IDLE);

	assign rd_en   = issue;
	assign rd_addr = idx_q[AW-1:0];

	assign wr_en   = (hit && (rd_data[VALUE_BITS] == MARK_ONCE)) || (miss && !full);
	assign wr_addr = hit ? cmp_idx_q[AW-1:0] : used_q[AW-1:0];
	assign wr_data = hit ? {MARK_MULTI, key_q} : {MARK_ONCE, key_q};

	assign sat            = (32'(once_q) > 32'(COUNT_MAX));
	assign res.once_count = sat ? COUNT_MAX : COUNT_W'(once_q);
	assign res.overflow   = ovf_q;
	assign res_valid      = (state_q == ST_FIN) && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= 1'b0;
			idx_q     <= '0;
			cmp_v_q   <= 1'b0;
			cmp_idx_q <= '0;
			used_q    <= '0;
			once_q    <= '0;
			ovf_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= key;
						last_q  <= last;
						idx_q   <= '0;
						cmp_v_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_v_q   <= issue;
					cmp_idx_q <= idx_q;
					if (issue) begin
						idx_q <= idx_q + UW'(1);
					end
					if (hit) begin
						if (rd_data[VALUE_BITS] == MARK_ONCE && once_q != '0) begin
							once_q <= once_q - UW'(1);
						end
						state_q <= ST_FIN;
					end else if (miss) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							used_q <= used_q + UW'(1);
							once_q <= once_q + UW'(1);
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (res_ready) begin
						used_q  <= '0;
						once_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/single_occurrence_counter_unit.sv]
// ----------------------------------------------------------------------------
// Single occurrence counter unit
// Counts the distinct values of a set that occur exactly once; one result
// word per set, given on the word flagged tlast. Each input word is
// finished before the next is taken: the used table entries are read one
// per cycle through the single RAM read port and checked by one comparator,
// then at most one entry is updated or appended. Words with a matching value
// stop the scan early. Values are compared on their low VALUE_BITS bits; the
// table holds CAPACITY distinct values, and a new value arriving when it is
// full is dropped and flagged in tuser. The table is emptied after each set.
// The result sits in an output register, so the next set may start while it
// waits.
// ----------------------------------------------------------------------------
module single_occurrence_counter_unit
	import socu_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [VALUE_W-1:0]    s_axis_tdata,  // [31:0] value
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [10:0] once_count, rest zero
	output logic [0:0]            m_axis_tuser   // [0] overflow
);

	localparam int AW = $clog2(CAPACITY);

	logic [63:0]           value_ext;
	logic [VALUE_BITS-1:0] key;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS:0]   wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS:0]   rd_data;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;
	logic                  out_valid_q;
	res_t                  out_res_q;

	assign value_ext = {32'b0, s_axis_tdata};
	assign key       = value_ext[VALUE_BITS-1:0];

	socu_ram #(
		.WIDTH(VALUE_BITS + 1),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	socu_seq #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.key      (key),
		.last     (s_axis_tlast),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - COUNT_W){1'b0}}, out_res_q.once_count};
	assign m_axis_tuser  = out_res_q.overflow;

endmodule

[sv/socu_checker.sv]
// ----------------------------------------------------------------------------
// Single occurrence counter checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "single_occurrence_counter_unit_macros.svh"

module socu_checker
	import socu_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [VALUE_W-1:0]    s_axis_tdata,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]            m_axis_tuser
);

	logic                in_word;
	logic                in_wait;
	logic                out_stall;
	logic [VALUE_W:0]    in_bits;
	logic [OUT_DATA_W:0] out_bits;

	assign in_word   = s_axis_tvalid && s_axis_tready;
	assign in_wait   = s_axis_tvalid && !s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign in_bits   = {s_axis_tlast, s_axis_tdata};
	assign out_bits  = {m_axis_tuser, m_axis_tdata};

	// a word is worked on before the next one is taken
	`SOCU_ASSERT_NXT(a_busy_after_word, clk, arst_n, in_word, !s_axis_tready)

	// a result appears only out of a busy cycle
	`SOCU_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

	// a result word holds while stalled
	`SOCU_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_bits))

	// an offered input word holds until taken
	`SOCU_ASSERT_NXT(a_in_hold, clk, arst_n, in_wait, s_axis_tvalid && $stable(in_bits))

endmodule

bind single_occurrence_counter_unit socu_checker u_socu_checker (.*);

[bench/tb_single_occurrence_counter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Single occurrence counter unit testbench
// Streams sets of signed 32-bit values, each closed by tlast, and predicts the
// count of values seen exactly once and the table-full flag per set. Covers
// extremes, repeats, single-bit neighbors, and one set that overruns the
// table. Both sides idle and stall in random bursts, including a long output
// hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_single_occurrence_counter_unit;
	import socu_pkg::*;

	localparam int LIMIT     = 3_000_000;
	localparam int LONG_HOLD = 400;
	localparam int TAIL      = 1100;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
		bit                 drain;
	} word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [VALUE_W-1:0]    s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	word_t word_q[$];
	res_t  due_counts[$];
	logic  value_mark[bit [VALUE_W-1:0]];
	int    once_total;
	logic  table_over;
	bit    word_taken;
	int    send_gap;
	int    stall_left;
	bit    held_long;
	int    results_seen;
	int    mismatches;
	int    cycle_cnt;

	single_occurrence_counter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// idling off in every third window and near the end
	function automatic bit calm();
		return ((cycle_cnt / 2000) % 3 == 0) || (word_q.size() < 60);
	endfunction

	task automatic tally_word(input logic [VALUE_W-1:0] v, input logic last);
		res_t r;
		if (value_mark.exists(v)) begin
			if (value_mark[v] == MARK_ONCE) begin
				value_mark[v] = MARK_MULTI;
				once_total--;
			end
		end else if (value_mark.num() < CAPACITY_DEF) begin
			value_mark[v] = MARK_ONCE;
			once_total++;
		end else begin
			table_over = 1'b1;
		end
		if (last) begin
			r.once_count = (once_total > COUNT_MAX) ? COUNT_MAX : once_total[COUNT_W-1:0];
			r.overflow = table_over;
			due_counts.push_back(r);
			value_mark.delete();
			once_total = 0;
			table_over = 1'b0;
		end
	endtask

	task automatic add_word(input logic [VALUE_W-1:0] v, input logic last, input bit drain);
		word_t w;
		w.value = v;
		w.last = last;
		w.drain = drain;
		word_q.push_back(w);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// mostly short sets drawn from a small pool so repeats are common
	task automatic add_random_set(output int n);
		logic [VALUE_W-1:0] pool[$];
		int npool;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
		npool = $urandom_range(1, n);
		for (int i = 0; i < npool; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0)
				pool.push_back(pool[$urandom_range(0, i - 1)] ^ (32'h1 << $urandom_range(0, 31)));
			else
				pool.push_back(pick_value());
		end
		for (int i = 0; i < n; i++)
			add_word(pool[$urandom_range(0, npool - 1)], i == n - 1, 1'b0);
	endtask

	// fills the table, then repeats stored values and offers new ones while full
	task automatic add_full_set();
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] step;
		base = $urandom;
		step = 32'h9E37_79B1;
		for (int i = 0; i < CAPACITY_DEF; i++)
			add_word(base + i * step, 1'b0, i == 0);
		add_word(base, 1'b0, 1'b0);
		add_word(base + 5 * step, 1'b0, 1'b0);
		add_word(base + 5 * step, 1'b0, 1'b0);
		for (int i = CAPACITY_DEF; i < CAPACITY_DEF + 6; i++)
			add_word(base + i * step, 1'b0, 1'b0);
		add_word(base + CAPACITY_DEF * step, 1'b0, 1'b0);
		add_word(base + 7 * step, 1'b1, 1'b0);
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t want;
		word_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (word_taken)
			tally_word(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (due_counts.size() == 0) begin
				$error("unexpected result word: once_count %0d overflow %0d",
					m_axis_tdata[COUNT_W-1:0], m_axis_tuser[0]);
				mismatches++;
			end else begin
				want = due_counts.pop_front();
				if (m_axis_tdata[COUNT_W-1:0] !== want.once_count) begin
					$error("once_count: expected %0d, got %0d", want.once_count,
						m_axis_tdata[COUNT_W-1:0]);
					mismatches++;
				end
				if (m_axis_tuser[0] !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, m_axis_tuser[0]);
					mismatches++;
				end
				if (m_axis_tdata[OUT_DATA_W-1:COUNT_W] !== '0) begin
					$error("tdata pad: expected 0, got %0h", m_axis_tdata[OUT_DATA_W-1:COUNT_W]);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		word_t w;
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (word_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (word_q[0].drain && due_counts.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				w = word_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= w.value;
				s_axis_tlast <= w.last;
				if (!calm() && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 15);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_long && results_seen >= 12) begin
				held_long = 1'b1;
				stall_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm() && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int n;
		int sent;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		once_total = 0;
		table_over = 1'b0;
		word_taken = 1'b0;
		send_gap = 0;
		stall_left = 0;
		held_long = 1'b0;
		results_seen = 0;
		mismatches = 0;
		cycle_cnt = 0;

		// single-word set
		add_word(32'h8000_0000, 1'b1, 1'b0);
		// extremes, last word repeats an earlier one
		add_word(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_word(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_word(32'h0000_0000, 1'b0, 1'b0);
		add_word(32'h7FFF_FFFF, 1'b1, 1'b0);
		// one value three times
		add_word(32'h1234_5678, 1'b0, 1'b0);
		add_word(32'h1234_5678, 1'b0, 1'b0);
		add_word(32'h1234_5678, 1'b1, 1'b0);
		// pairs interleaved
		add_word(32'hA5A5_A5A5, 1'b0, 1'b0);
		add_word(32'h5A5A_5A5A, 1'b0, 1'b0);
		add_word(32'hA5A5_A5A5, 1'b0, 1'b0);
		add_word(32'h5A5A_5A5A, 1'b1, 1'b0);
		// neighbors in the low and sign bits
		add_word(32'h0000_0001, 1'b0, 1'b0);
		add_word(32'h0000_0000, 1'b0, 1'b0);
		add_word(32'h8000_0001, 1'b0, 1'b0);
		add_word(32'h8000_0000, 1'b1, 1'b0);
		// distinct values, last repeats the first
		add_word(32'hDEAD_BEEF, 1'b0, 1'b0);
		add_word(32'h0000_FFFF, 1'b0, 1'b0);
		add_word(32'hFFFF_0000, 1'b0, 1'b0);
		add_word(32'h0F0F_0F0F, 1'b0, 1'b0);
		add_word(32'hF0F0_F0F0, 1'b0, 1'b0);
		add_word(32'hDEAD_BEEF, 1'b1, 1'b0);

		sent = 0;
		while (sent < 400) begin
			add_random_set(n);
			sent += n;
		end
		add_full_set();
		while (sent < 800) begin
			add_random_set(n);
			sent += n;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (word_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (due_counts.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[single_occurrence_counter_unit.f]
+incdir+sv
sv/socu_pkg.sv
sv/socu_ram.sv
sv/socu_seq.sv
sv/single_occurrence_counter_unit.sv
sv/socu_checker.sv
bench/tb_single_occurrence_counter_unit.sv
